// File: hdl/pdm_slm_pkg.sv
// Shared types, constants and helper functions for the PDM sound level meter.
// Used by every module of the block; depends on nothing else.
package pdm_slm_pkg;

  localparam int WORD_W    = 16;
  localparam int HIST_W    = 15;
  localparam int DEV_W     = 4;
  localparam int NUM_DEV   = 16;
  localparam int HIST_DEVS = 15;
  localparam int WIN_DEVS  = 31;
  localparam int WGT_W     = 5;
  localparam int ONES_W    = 5;
  localparam int SUM_W     = 12;
  localparam int LEVEL_W   = 17;
  localparam int FW_W      = 7;
  localparam int THR_W     = 17;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam int DEF_MAX_FRAME_WORDS = 64;
  localparam int MIN_FRAME_WORDS     = 2;

  localparam logic [FW_W-1:0]    FRAME_WORDS_RESET = 7'd50;
  localparam logic [THR_W-1:0]   THRESHOLD_RESET   = 17'd8000;
  localparam logic [LEVEL_W-1:0] LEVEL_SAT         = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_PEAK        = 17'd127232;
  localparam logic [ONES_W-1:0]  ONES_MID          = 5'd8;

  typedef enum logic [0:0] {
    REG_FRAME_WORDS    = 1'b0,
    REG_LOUD_THRESHOLD = 1'b1
  } reg_sel_t;

  typedef logic [DEV_W-1:0] dev_t;

  // where a word sits in its frame
  typedef struct packed {
    logic first;
    logic second;
    logic last;
  } slm_tag_t;

  // |ones - 8| over one 16-bit window
  function automatic dev_t window_dev(input logic [WORD_W-1:0] w);
    logic [ONES_W-1:0] ones;
    ones = '0;
    for (int i = 0; i < WORD_W; i++) begin
      ones = ones + ONES_W'(w[i]);
    end
    if (ones >= ONES_MID) begin
      return DEV_W'(ones - ONES_MID);
    end else begin
      return DEV_W'(ONES_MID - ones);
    end
  endfunction

  // Number of counted 16-long runs that cover deviation j of the 31-entry
  // window. In the frame's second word only the last two runs count.
  function automatic logic [WGT_W-1:0] run_weight(input int j, input logic second);
    int lo;
    int hi;
    int w;
    if (second) begin
      w = ((j >= 14 && j <= 29) ? 1 : 0) + ((j >= 15 && j <= 30) ? 1 : 0);
    end else begin
      lo = (j > 15) ? j - 15 : 0;
      hi = (j < 15) ? j : 15;
      w  = hi - lo + 1;
    end
    return WGT_W'(w);
  endfunction

endpackage

// File: hdl/pdm_sound_level_meter_unit.sv
// PDM sound level meter, top level. Takes one 16-bit PDM word per cycle while in_stall is low.
// Four register stages (input, deviations, run totals, accumulator/result):
// a frame's last word passes them in that order before its result shows.
// in_stall rises only while a result waits.
// Synchronous reset empties the pipeline, restarts the frame and loads the
// register defaults (50 words per frame, threshold 8000).
module pdm_sound_level_meter_unit #(
  parameter int MAX_FRAME_WORDS = pdm_slm_pkg::DEF_MAX_FRAME_WORDS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pdm_slm_pkg::WORD_W-1:0]    pdm_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pdm_slm_pkg::LEVEL_W-1:0]   level,
  output logic                              loud,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pdm_slm_pkg::APB_AW-1:0]    paddr,
  input  logic [pdm_slm_pkg::APB_DW-1:0]    pwdata,
  output logic [pdm_slm_pkg::APB_DW-1:0]    prdata,
  output logic                              pready
);
  import pdm_slm_pkg::*;

  logic [FW_W-1:0]                  frame_words;
  logic [THR_W-1:0]                 loud_threshold;

  logic                             s1_valid;
  logic [WORD_W-1:0]                s1_word;
  logic [HIST_W-1:0]                s1_prev;
  slm_tag_t                         s1_tag;
  logic                             s1_free;

  logic                             s2_valid;
  logic [WIN_DEVS-1:0][DEV_W-1:0]   s2_win;
  slm_tag_t                         s2_tag;
  logic                             s2_free;

  logic                             s3_valid;
  logic [SUM_W-1:0]                 s3_sum;
  slm_tag_t                         s3_tag;
  logic                             s3_take;

  // a stage loads when it is empty or its item moves on
  assign s2_free  = !s2_valid || s3_take;
  assign s1_free  = !s1_valid || s2_free;
  assign in_stall = !s1_free;

  pdm_slm_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .frame_words    (frame_words),
    .loud_threshold (loud_threshold)
  );

  pdm_slm_front #(
    .MAX_FRAME_WORDS (MAX_FRAME_WORDS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .pdm_word    (pdm_word),
    .load        (s1_free),
    .frame_words (frame_words),
    .s1_valid    (s1_valid),
    .s1_word     (s1_word),
    .s1_prev     (s1_prev),
    .s1_tag      (s1_tag)
  );

  pdm_slm_dev u_dev (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_word  (s1_word),
    .s1_prev  (s1_prev),
    .s1_tag   (s1_tag),
    .load     (s2_free),
    .s2_valid (s2_valid),
    .s2_win   (s2_win),
    .s2_tag   (s2_tag)
  );

  pdm_slm_sum u_sum (
    .clk      (clk),
    .rst      (rst),
    .s2_valid (s2_valid),
    .s2_win   (s2_win),
    .s2_tag   (s2_tag),
    .load     (s3_take),
    .s3_valid (s3_valid),
    .s3_sum   (s3_sum),
    .s3_tag   (s3_tag)
  );

  pdm_slm_acc u_acc (
    .clk            (clk),
    .rst            (rst),
    .s3_valid       (s3_valid),
    .s3_sum         (s3_sum),
    .s3_tag         (s3_tag),
    .loud_threshold (loud_threshold),
    .out_stall      (out_stall),
    .s3_take        (s3_take),
    .out_valid      (out_valid),
    .level          (level),
    .loud           (loud)
  );

endmodule

// File: hdl/pdm_slm_regs.sv
// Configuration registers behind an APB-style port: frame length and threshold.
// Depends on pdm_slm_pkg.
module pdm_slm_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pdm_slm_pkg::APB_AW-1:0]     paddr,
  input  logic [pdm_slm_pkg::APB_DW-1:0]     pwdata,
  output logic [pdm_slm_pkg::APB_DW-1:0]     prdata,
  output logic                               pready,
  output logic [pdm_slm_pkg::FW_W-1:0]       frame_words,
  output logic [pdm_slm_pkg::THR_W-1:0]      loud_threshold
);
  import pdm_slm_pkg::*;

  logic     wr_en;
  reg_sel_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_sel_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_words    <= FRAME_WORDS_RESET;
      loud_threshold <= THRESHOLD_RESET;
    end else if (wr_en) begin
      case (sel)
        REG_FRAME_WORDS:    frame_words    <= pwdata[FW_W-1:0];
        REG_LOUD_THRESHOLD: loud_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_FRAME_WORDS:    prdata = APB_DW'(frame_words);
      REG_LOUD_THRESHOLD: prdata = APB_DW'(loud_threshold);
      default:            prdata = '0;
    endcase
  end

endmodule

// File: hdl/pdm_slm_front.sv
// Input stage: registers the PDM word with the previous word's bits and
// tracks the word position within the frame. Depends on pdm_slm_pkg.
module pdm_slm_front #(
  parameter int MAX_FRAME_WORDS = pdm_slm_pkg::DEF_MAX_FRAME_WORDS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [pdm_slm_pkg::WORD_W-1:0]   pdm_word,
  input  logic                             load,
  input  logic [pdm_slm_pkg::FW_W-1:0]     frame_words,
  output logic                             s1_valid,
  output logic [pdm_slm_pkg::WORD_W-1:0]   s1_word,
  output logic [pdm_slm_pkg::HIST_W-1:0]   s1_prev,
  output pdm_slm_pkg::slm_tag_t            s1_tag
);
  import pdm_slm_pkg::*;

  localparam int POS_W = (MAX_FRAME_WORDS > 2) ? $clog2(MAX_FRAME_WORDS) : 1;

  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [POS_W-1:0]  last_pos;
  logic [FW_W-1:0]   fw_eff;
  logic [HIST_W-1:0] bit_hist;
  logic              accept;
  slm_tag_t          tag;

  assign accept = in_valid && load;

  // clamp the frame length to the supported range
  always_comb begin
    if (frame_words < FW_W'(MIN_FRAME_WORDS)) begin
      fw_eff = FW_W'(MIN_FRAME_WORDS);
    end else if (frame_words > FW_W'(MAX_FRAME_WORDS)) begin
      fw_eff = FW_W'(MAX_FRAME_WORDS);
    end else begin
      fw_eff = frame_words;
    end
    last_pos   = POS_W'(fw_eff - FW_W'(1));
    tag.first  = (pos == '0);
    tag.second = (pos == POS_W'(1));
    tag.last   = (pos >= last_pos);
    pos_next   = tag.last ? '0 : pos + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pos      <= '0;
    end else begin
      if (load) begin
        s1_valid <= in_valid;
      end
      if (accept) begin
        pos <= pos_next;
      end
    end
  end

  // a frame start sees an all-zero bit history
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word  <= pdm_word;
      s1_prev  <= tag.first ? '0 : bit_hist;
      s1_tag   <= tag;
      bit_hist <= pdm_word[HIST_W-1:0];
    end
  end

endmodule

// File: hdl/pdm_slm_dev.sv
// Deviation stage: sixteen window ones-counts per word, each turned into
// |count-8|, joined with the previous word's deviations. Depends on pdm_slm_pkg.
module pdm_slm_dev (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                s1_valid,
  input  logic [pdm_slm_pkg::WORD_W-1:0]                      s1_word,
  input  logic [pdm_slm_pkg::HIST_W-1:0]                      s1_prev,
  input  pdm_slm_pkg::slm_tag_t                               s1_tag,
  input  logic                                                load,
  output logic                                                s2_valid,
  output logic [pdm_slm_pkg::WIN_DEVS-1:0][pdm_slm_pkg::DEV_W-1:0] s2_win,
  output pdm_slm_pkg::slm_tag_t                               s2_tag
);
  import pdm_slm_pkg::*;

  logic [WORD_W+HIST_W-1:0]            bits;
  logic [NUM_DEV-1:0][DEV_W-1:0]       dev_cur;
  logic [HIST_DEVS-1:0][DEV_W-1:0]     dev_hist;
  logic                                move;

  assign bits = {s1_prev, s1_word};
  assign move = s1_valid && load;

  // drop windows that would reach back before the frame start
  always_comb begin
    for (int k = 0; k < NUM_DEV; k++) begin
      if (s1_tag.first && k < NUM_DEV - 1) begin
        dev_cur[k] = '0;
      end else begin
        dev_cur[k] = window_dev(bits[(NUM_DEV-1-k) +: WORD_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (load) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      for (int j = 0; j < HIST_DEVS; j++) begin
        s2_win[j]   <= s1_tag.first ? '0 : dev_hist[j];
        dev_hist[j] <= dev_cur[j+1];
      end
      for (int k = 0; k < NUM_DEV; k++) begin
        s2_win[HIST_DEVS+k] <= dev_cur[k];
      end
      s2_tag <= s1_tag;
    end
  end

endmodule

// File: hdl/pdm_slm_sum.sv
// Run-sum stage: total of all counted 16-long deviation runs of one word,
// formed as a weighted sum of the 31-entry window. Depends on pdm_slm_pkg.
module pdm_slm_sum (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                s2_valid,
  input  logic [pdm_slm_pkg::WIN_DEVS-1:0][pdm_slm_pkg::DEV_W-1:0] s2_win,
  input  pdm_slm_pkg::slm_tag_t                               s2_tag,
  input  logic                                                load,
  output logic                                                s3_valid,
  output logic [pdm_slm_pkg::SUM_W-1:0]                       s3_sum,
  output pdm_slm_pkg::slm_tag_t                               s3_tag
);
  import pdm_slm_pkg::*;

  logic [SUM_W-1:0] total;

  // no run is complete within the frame's first word
  always_comb begin
    total = '0;
    for (int j = 0; j < WIN_DEVS; j++) begin
      total = total + SUM_W'(s2_win[j]) * SUM_W'(run_weight(j, s2_tag.second));
    end
    if (s2_tag.first) begin
      total = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (load) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && load) begin
      s3_sum <= total;
      s3_tag <= s2_tag;
    end
  end

endmodule

// File: hdl/pdm_slm_acc.sv
// Frame accumulator and result register: adds each word's run total and
// presents level and loud on the frame's last word. Depends on pdm_slm_pkg.
module pdm_slm_acc (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s3_valid,
  input  logic [pdm_slm_pkg::SUM_W-1:0]     s3_sum,
  input  pdm_slm_pkg::slm_tag_t             s3_tag,
  input  logic [pdm_slm_pkg::THR_W-1:0]     loud_threshold,
  input  logic                              out_stall,
  output logic                              s3_take,
  output logic                              out_valid,
  output logic [pdm_slm_pkg::LEVEL_W-1:0]   level,
  output logic                              loud
);
  import pdm_slm_pkg::*;

  logic [LEVEL_W-1:0] acc;
  logic [LEVEL_W-1:0] acc_base;
  logic [LEVEL_W:0]   acc_sum;
  logic [LEVEL_W-1:0] acc_next;
  logic               out_free;
  logic               consume;
  logic               emit;

  assign out_free = !out_valid || !out_stall;
  assign s3_take  = !s3_valid || !s3_tag.last || out_free;
  assign consume  = s3_valid && (!s3_tag.last || out_free);
  assign emit     = consume && s3_tag.last;

  // restart at a frame start, saturate on overflow
  always_comb begin
    acc_base = s3_tag.first ? '0 : acc;
    acc_sum  = {1'b0, acc_base} + (LEVEL_W+1)'(s3_sum);
    acc_next = acc_sum[LEVEL_W] ? LEVEL_SAT : acc_sum[LEVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      acc <= acc_next;
    end
    if (emit) begin
      level <= acc_next;
      loud  <= (acc_next > loud_threshold);
    end
  end

endmodule

// File: hdl/pdm_slm_checker.sv
// Port-level checks for the PDM sound level meter, attached by bind.
// Depends on pdm_slm_pkg and the top level pdm_sound_level_meter_unit.
module pdm_slm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [pdm_slm_pkg::LEVEL_W-1:0]   level,
  input logic                              loud
);
  import pdm_slm_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(level) && $stable(loud))
    else $error("result changed while stalled");

  // with no result pending the input side never stalls
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty result register");

  // a frame of at most the largest length cannot pass the peak level
  a_level_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level <= LEVEL_PEAK)
    else $error("level above the largest reachable frame level");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending right after reset");

endmodule

bind pdm_sound_level_meter_unit pdm_slm_checker u_pdm_slm_checker (.*);
